// ===== src/sdf_pkg.sv =====
// Package for the signed decimal formatter.
// Holds the sequencer state type and the character and digit constants.
// No dependencies.
package sdf_pkg;

  localparam int VALUE_W    = 64;
  localparam int NUM_DIGITS = 19;
  localparam int BCD_W      = 4 * NUM_DIGITS;

  localparam logic [4:0] MAX_WIDTH  = 5'd19;
  localparam logic [4:0] MAX_LEAD   = 5'd18;
  localparam logic [5:0] LAST_SHIFT = 6'd63;

  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_MINUS = 7'h2D;
  localparam logic [6:0] CHAR_PLUS  = 7'h2B;
  localparam logic [6:0] CHAR_SPACE = 7'h20;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_NORM,
    ST_EMIT
  } state_t;

endpackage

// ===== src/signed_decimal_formatter.sv =====
// Signed decimal formatter: turns a signed 64-bit value into decimal ASCII text.
// Depends on sdf_pkg for the sequencer state type and character constants.
//
// The block takes one item holding a signed 64-bit value and three format
// options, and returns its decimal text as a stream of ASCII characters, most
// significant first, one character per output item. The last character is
// marked by tlast and carries the total text length; earlier characters carry
// a length of zero. A '+' can be requested for non-negative values, a '-'
// always precedes negative ones. The minimum width counts digits and padding
// but not the sign and is clamped to 19. Zero padding goes between the sign
// and the digits; space padding goes left of the sign slot, and in that case
// the slot is always present and holds a space when there is no sign.
// Sequence: the item is accepted in an idle cycle. The shift-and-add-3
// binary-to-decimal unit then handles one magnitude bit per cycle; after that,
// leading zero digits shift out of the decimal register, one digit per
// cycle, and the layout is set up; then one character leaves per cycle
// while the output is not stalled. The text has 1 to 19 digits and 1 to 20
// characters. s_tready is high only while the block is idle, which
// includes the time in which the final character still waits in the
// output register.
module signed_decimal_formatter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // Fields from bit 0 up: value[63:0], show_plus[64], zero_pad[65],
  // min_width[70:66], zero fill[71].
  input  logic [71:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // Fields from bit 0 up: out_char[6:0], length[11:7], zero fill[15:12].
  output logic [15:0] m_tdata,
  output logic        m_tlast
);
  import sdf_pkg::*;

  state_t state, state_next;

  // Conversion datapath: magnitude shifts out of mag into the BCD register.
  logic [VALUE_W-1:0] mag;
  logic [BCD_W-1:0]   bcd;
  logic [BCD_W-1:0]   bcd_adj;
  logic [5:0]         cnt;
  logic [4:0]         lead;

  // Captured options.
  logic       neg;
  logic       plus;
  logic       zpad;
  logic [4:0] width;

  // Layout of the text, fixed when normalization ends.
  logic       sslot;
  logic [4:0] spos;
  logic [4:0] plo;
  logic [4:0] phi;
  logic [4:0] total;
  logic [4:0] k;

  logic [6:0] out_char;
  logic [4:0] out_len;

  // Sequencer strobes.
  logic conv_step;
  logic norm_shift;
  logic emit_fire;
  logic in_fire;
  logic emit_done;

  // Input unpacking.
  logic [VALUE_W-1:0] in_value;
  logic [4:0]         in_width;
  assign in_value = s_tdata[63:0];
  assign in_width = (s_tdata[70:66] > MAX_WIDTH) ? MAX_WIDTH : s_tdata[70:66];

  // Layout computed from the digit count once leading zeros are gone.
  logic [4:0] digits;
  logic       wide;
  logic       space_mode;
  logic       has_sign;
  logic [4:0] npad_c;
  logic [4:0] plo_c;
  assign digits     = 5'd19 - lead;
  assign wide       = width > digits;
  assign space_mode = !zpad && wide;
  assign has_sign   = neg || plus;
  assign npad_c     = wide ? (width - digits) : 5'd0;
  assign plo_c      = space_mode ? 5'd0 : {4'd0, has_sign};

  // Add-3 correction on every digit, done in parallel before each shift.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? (bcd[4*i +: 4] + 4'd3)
                                                  : bcd[4*i +: 4];
    end
  end

  // Character selection for the current text position.
  logic [6:0] sign_char;
  logic [6:0] pad_char;
  logic [6:0] char_c;
  logic       is_digit;
  assign sign_char = neg ? CHAR_MINUS : (plus ? CHAR_PLUS : CHAR_SPACE);
  assign pad_char  = zpad ? CHAR_ZERO : CHAR_SPACE;

  always_comb begin
    is_digit = 1'b0;
    if (sslot && (k == spos)) begin
      char_c = sign_char;
    end else if ((k >= plo) && (k < phi)) begin
      char_c = pad_char;
    end else begin
      char_c   = {3'b011, bcd[BCD_W-1 -: 4]};
      is_digit = 1'b1;
    end
  end

  // Strobes.
  always_comb begin
    s_tready   = (state == ST_IDLE);
    in_fire    = s_tvalid && s_tready;
    conv_step  = (state == ST_CONV);
    norm_shift = (state == ST_NORM) && (bcd[BCD_W-1 -: 4] == 4'd0) && (lead < MAX_LEAD);
    emit_fire  = (state == ST_EMIT) && (!m_tvalid || m_tready);
    emit_done  = emit_fire && (k == total - 5'd1);
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_CONV;
      end
      ST_CONV: begin
        if (cnt == LAST_SHIFT) state_next = ST_NORM;
      end
      ST_NORM: begin
        if (!norm_shift) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_done) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit_fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      neg   <= in_value[VALUE_W-1];
      mag   <= in_value[VALUE_W-1] ? (~in_value + 64'd1) : in_value;
      plus  <= s_tdata[64];
      zpad  <= s_tdata[65];
      width <= in_width;
      bcd   <= '0;
      cnt   <= '0;
      lead  <= '0;
    end
    if (conv_step) begin
      bcd <= {bcd_adj[BCD_W-2:0], mag[VALUE_W-1]};
      mag <= {mag[VALUE_W-2:0], 1'b0};
      cnt <= cnt + 6'd1;
    end
    if (norm_shift) begin
      bcd  <= {bcd[BCD_W-5:0], 4'd0};
      lead <= lead + 5'd1;
    end
    if ((state == ST_NORM) && !norm_shift) begin
      sslot <= space_mode || has_sign;
      spos  <= space_mode ? npad_c : 5'd0;
      plo   <= plo_c;
      phi   <= plo_c + npad_c;
      total <= npad_c + {4'd0, space_mode || has_sign} + digits;
      k     <= '0;
    end
    if (emit_fire) begin
      out_char <= char_c;
      m_tlast  <= emit_done;
      out_len  <= emit_done ? total : 5'd0;
      k        <= k + 5'd1;
      if (is_digit) begin
        bcd <= {bcd[BCD_W-5:0], 4'd0};
      end
    end
  end

  assign m_tdata = {4'd0, out_len, out_char};

  // Assertions.
  a_start_conv: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state == ST_CONV))
    else $error("accepted item did not start conversion");

  a_busy_emit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> !s_tready)
    else $error("input ready while characters remain");

  a_len_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> ((out_len >= 5'd1) && (out_len <= 5'd20)))
    else $error("final character carries bad length");

  a_len_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (out_len == 5'd0))
    else $error("non-final character carries a length");

  a_legal_char: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (((out_char >= CHAR_ZERO) && (out_char <= 7'h39)) ||
                  (out_char == CHAR_MINUS) || (out_char == CHAR_PLUS) ||
                  (out_char == CHAR_SPACE)))
    else $error("illegal character emitted");

endmodule

// ===== test/sdf_text_checker.sv =====
`timescale 1ns / 1ps
// Checker for the signed decimal formatter: watches both streams, predicts text.
// Depends on sdf_pkg for the digit count and the ASCII character constants.
module sdf_text_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  // Fields from bit 0 up: value[63:0], show_plus[64], zero_pad[65],
  // min_width[70:66], zero fill[71].
  input  logic [71:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  // Fields from bit 0 up: out_char[6:0], length[11:7], zero fill[15:12].
  input  logic [15:0] m_tdata,
  input  logic        m_tlast,
  output int          fail_count,
  output int          chars_pending
);
  import sdf_pkg::*;

  localparam int PRINT_CAP = 40;

  typedef struct packed {
    logic [6:0] ch;
    logic       fin;
    logic [4:0] len;
  } text_char_t;

  text_char_t expected_chars[$];
  text_char_t want;

  initial begin
    fail_count    = 0;
    chars_pending = 0;
  end

  task automatic report_mismatch(input string msg);
    fail_count = fail_count + 1;
    if (fail_count <= PRINT_CAP) $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  // Builds the decimal text of one number and queues its characters.
  function automatic void format_decimal(input logic [63:0] value, input logic show_plus,
                                         input logic zero_pad, input logic [4:0] min_width);
    logic        neg;
    logic        has_sign;
    logic [63:0] mag;
    logic [63:0] rem;
    logic [6:0]  sign_char;
    logic [6:0]  digits[NUM_DIGITS];
    logic [6:0]  txt[20];
    logic [4:0]  width;
    int          nd;
    int          n;
    text_char_t  item;
    neg       = value[63];
    mag       = neg ? (64'd0 - value) : value;
    has_sign  = neg || show_plus;
    sign_char = neg ? CHAR_MINUS : CHAR_PLUS;
    width     = (min_width > MAX_WIDTH) ? MAX_WIDTH : min_width;
    nd        = 0;
    n         = 0;
    // Digits come out least significant first; the most negative value
    // still fits in nineteen of them.
    do begin
      rem        = mag % 64'd10;
      digits[nd] = CHAR_ZERO + rem[6:0];
      mag        = mag / 64'd10;
      nd++;
    end while (mag != 64'd0 && nd < NUM_DIGITS);
    if (!zero_pad && width > nd) begin
      // Spaces go left of the sign slot, which is a space when unsigned.
      repeat (width - nd) begin
        txt[n] = CHAR_SPACE;
        n++;
      end
      txt[n] = has_sign ? sign_char : CHAR_SPACE;
      n++;
    end else begin
      if (has_sign) begin
        txt[n] = sign_char;
        n++;
      end
      if (zero_pad && width > nd) begin
        repeat (width - nd) begin
          txt[n] = CHAR_ZERO;
          n++;
        end
      end
    end
    for (int i = nd; i > 0; i--) begin
      txt[n] = digits[i - 1];
      n++;
    end
    for (int k = 0; k < n; k++) begin
      item.ch  = txt[k];
      item.fin = (k == n - 1);
      item.len = item.fin ? n[4:0] : 5'd0;
      expected_chars.push_back(item);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        format_decimal(s_tdata[63:0], s_tdata[64], s_tdata[65], s_tdata[70:66]);
      end
      if (m_tvalid && m_tready) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("character 0x%02h arrived with no text pending",
                                    m_tdata[6:0]));
        end else begin
          want = expected_chars.pop_front();
          if (m_tdata[6:0] !== want.ch)
            report_mismatch($sformatf("char got 0x%02h want 0x%02h", m_tdata[6:0], want.ch));
          if (m_tlast !== want.fin)
            report_mismatch($sformatf("last got %b want %b", m_tlast, want.fin));
          if (m_tdata[11:7] !== want.len)
            report_mismatch($sformatf("length got %0d want %0d", m_tdata[11:7], want.len));
        end
      end
    end
    chars_pending <= expected_chars.size();
  end

endmodule

// ===== test/signed_decimal_formatter_tb.sv =====
`timescale 1ns / 1ps
// Top of the signed decimal formatter testbench: clock, reset, stimulus, verdict.
// Depends on sdf_pkg, the formatter and the sdf_text_checker module.
module signed_decimal_formatter_tb;
  import sdf_pkg::*;

  // The watchdog fires after this many cycles without a single handshake.
  // The slowest legal stretch is the longest send gap plus a full conversion,
  // or the longest output stall, so this is many times over.
  localparam int STALL_LIMIT = 4000;
  // Quiet cycles after the last character, longer than one full conversion,
  // so that any stray extra character is caught.
  localparam int DRAIN_CYCLES = 120;
  localparam int RANDOM_ITEMS = 126;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // Fields from bit 0 up: value[63:0], show_plus[64], zero_pad[65],
  // min_width[70:66], zero fill[71].
  logic [71:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // Fields from bit 0 up: out_char[6:0], length[11:7], zero fill[15:12].
  logic [15:0] m_tdata;
  logic        m_tlast;

  int fail_count;
  int chars_pending;
  int quiet_cycles = 0;
  // When set, neither side inserts any idle cycles.
  logic no_idle = 1'b0;

  signed_decimal_formatter dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  sdf_text_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast),
    .fail_count    (fail_count),
    .chars_pending (chars_pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Draws the number of idle cycles before the next item on either side.
  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 14);
  endfunction

  // Offers one number to the block and returns at the edge where it is taken.
  // The valid stays high on return, so a back-to-back item only updates the
  // data and never lowers and raises valid in the same time step.
  task automatic send_number(input logic [63:0] value, input logic show_plus,
                             input logic zero_pad, input logic [4:0] min_width);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, min_width, zero_pad, show_plus, value};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Sends a number drawn to hit digit-count boundaries, extremes, small and 32-bit
  // values and full random bit patterns, with random options.
  task automatic send_random_number();
    logic [63:0] value;
    logic [63:0] pow10;
    logic [4:0]  min_width;
    pow10 = 64'd1;
    case ($urandom_range(0, 5))
      0, 5: value = {$urandom, $urandom};
      1: value = 64'($urandom_range(0, 999));
      2: begin
        repeat ($urandom_range(0, 18)) pow10 = pow10 * 64'd10;
        value = $urandom_range(0, 1) ? pow10 : pow10 - 64'd1;
      end
      3: begin
        case ($urandom_range(0, 3))
          0: value = {1'b1, 63'd0};
          1: value = {1'b0, {63{1'b1}}};
          2: value = 64'd0;
          default: value = {64{1'b1}};
        endcase
      end
      default: value = {32'd0, $urandom};
    endcase
    if ($urandom_range(0, 1)) value = 64'd0 - value;
    // Most widths fall near the useful range; the rest exercise the clamp.
    min_width = $urandom_range(0, 3) != 0 ? 5'($urandom_range(0, 21))
                                          : 5'($urandom_range(0, 31));
    send_number(value, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), min_width);
  endtask

  // Receiver: waits a random number of cycles before each character, then
  // stays ready until a character is taken.
  initial begin : sink
    int gap;
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  // Watchdog: counts cycles in which neither stream moves an item.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Zero with and without a plus sign and with space and zero padding, including
    // the case where space padding with no sign leaves the sign slot as a space.
    send_number(64'd0, 1'b0, 1'b0, 5'd0);
    send_number(64'd0, 1'b1, 1'b0, 5'd0);
    send_number(64'd0, 1'b0, 1'b0, 5'd5);
    send_number(64'd0, 1'b1, 1'b0, 5'd5);
    send_number(64'd0, 1'b0, 1'b1, 5'd5);
    send_number(64'd0, 1'b1, 1'b1, 5'd5);
    // Minus one with space and zero padding.
    send_number({64{1'b1}}, 1'b0, 1'b0, 5'd0);
    send_number({64{1'b1}}, 1'b0, 1'b0, 5'd3);
    send_number({64{1'b1}}, 1'b0, 1'b1, 5'd3);
    // Largest and most negative values; width equal to the digit count
    // gives no padding, a width above 19 is clamped.
    send_number({1'b0, {63{1'b1}}}, 1'b0, 1'b0, 5'd0);
    send_number({1'b0, {63{1'b1}}}, 1'b1, 1'b1, 5'd19);
    send_number({1'b1, 63'd0}, 1'b0, 1'b0, 5'd0);
    send_number({1'b1, 63'd0}, 1'b0, 1'b1, 5'd19);
    send_number({1'b1, 63'd0}, 1'b0, 1'b0, 5'd19);
    send_number({1'b1, 63'd0}, 1'b1, 1'b0, 5'd31);
    // Width exactly at and one above the digit count.
    send_number(64'd12345, 1'b0, 1'b0, 5'd5);
    send_number(64'd12345, 1'b0, 1'b0, 5'd6);
    send_number(64'd0 - 64'd12345, 1'b0, 1'b1, 5'd6);
    // The longest text: clamped width, one digit, space padding and a sign.
    send_number(64'd9, 1'b1, 1'b0, 5'd31);
    send_number(64'd10, 1'b0, 1'b1, 5'd31);
    send_number(64'd0 - 64'd10, 1'b1, 1'b1, 5'd2);
    send_number(64'd1, 1'b0, 1'b0, 5'd19);
    // Eighteen nines and ten to the eighteenth sit on the digit boundary.
    send_number(64'd999999999999999999, 1'b0, 1'b0, 5'd19);
    send_number(64'd1000000000000000000, 1'b1, 1'b0, 5'd20);

    // Random part: idling on both sides, then a stretch with none, then
    // idling again.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      no_idle = (i >= 60 && i < 100);
      send_random_number();
    end
    no_idle = 1'b0;
    s_tvalid <= 1'b0;

    // The count seen here was updated at an earlier edge, so the last
    // number's characters are already counted.
    @(posedge clk);
    while (chars_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/sdf_pkg.sv
src/signed_decimal_formatter.sv
test/sdf_text_checker.sv
test/signed_decimal_formatter_tb.sv
